// File: hw/rtl/bcd_pkg.sv
// shared types and constants of the button chain debouncer
package bcd_pkg;

    localparam int MAX_BUTTONS_DEFAULT = 128;
    localparam int LANES = 8;
    localparam int CNT_W = 8;
    localparam int ROW_CNT_W = LANES * CNT_W;

    localparam logic [7:0] THRESHOLD_RESET = 8'd10;
    localparam logic [7:0] BUTTON_COUNT_RESET = 8'd10;
    localparam logic ACTIVE_LOW_RESET = 1'b1;

    typedef enum logic [1:0] {
        CFG_THRESHOLD    = 2'd0,
        CFG_BUTTON_COUNT = 2'd1,
        CFG_ACTIVE_LOW   = 2'd2,
        CFG_UNUSED       = 2'd3
    } cfg_index_t;

    typedef enum logic {
        CMD_DEBOUNCE = 1'b0,
        CMD_PRIME    = 1'b1
    } command_t;

    typedef struct packed {
        logic       command;
        logic [3:0] byte_index;
        logic [7:0] raw_byte;
    } bcd_in_t;

    typedef struct packed {
        logic [7:0] button_number;
        logic       pressed;
        logic       last_event;
    } bcd_out_t;

    typedef struct packed {
        logic [1:0] index;
        logic [7:0] data;
    } bcd_cfg_t;

    // hand-off of one debounced byte to the event emitter
    typedef struct packed {
        logic             valid;
        logic [LANES-1:0] mask;
        logic [LANES-1:0] press;
        logic [3:0]       byte_index;
    } bcd_load_t;

endpackage

// File: hw/rtl/bcd_stream_if.sv
// valid/ready channel with a typed payload
interface bcd_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// File: hw/rtl/button_chain_debouncer.sv
// top level of the button chain debouncer
//
// scan (sink): one byte of the button chain per transfer: command (debounce or
// prime), byte_index and raw_byte. evt (source): one transfer per accepted
// press or release, in ascending button order, last_event set on the final
// event of a byte. cfg (sink): register writes, index 0 threshold,
// 1 button_count, 2 active_low; always ready, other indexes are dropped.
// The first event of a byte is offered once the byte has passed the ram stage
// register and been loaded into the emitter's mask register. The emitter's
// output register holds a single event, so a byte with events holds it until
// its last event is taken; a byte with no events does not hold it.
// Stable levels and counters sit in two rams, one row per byte, read when the
// byte is taken and written back as it leaves the ram stage; a back-to-back
// byte of the same row takes the written data from a forwarding register.
// Reset: registers return to their defaults and the row valid bits clear, so
// every row reads as zero; no clearing pass, scan is ready at once.
// A stalled evt holds its event; one further byte is still taken and waits
// in the ram stage, then scan.ready drops until the emitter frees up.
module button_chain_debouncer #(
    parameter int MAX_BUTTONS = bcd_pkg::MAX_BUTTONS_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    bcd_stream_if.sink cfg,
    bcd_stream_if.sink scan,
    bcd_stream_if.source evt
);
    import bcd_pkg::*;

    localparam int STABLE_BYTES = (MAX_BUTTONS + 7) / 8;
    localparam int ROWS = (STABLE_BYTES < 16) ? STABLE_BYTES : 16;
    localparam int AW = (ROWS > 2) ? $clog2(ROWS) : 1;
    localparam int DEPTH = 2 ** AW;
    localparam int IW = $clog2(MAX_BUTTONS + 1);
    localparam int CW = (IW > 8) ? IW : 8;

    logic [7:0] threshold_reg;
    logic [7:0] button_count_reg;
    logic       active_low_reg;

    // accept side
    logic             scan_xfer;
    logic             beyond;
    logic [7:0]       inv_byte;
    logic [LANES-1:0] used;
    logic [AW-1:0]    rd_addr;
    logic             rd_en;

    // ram stage
    logic             s1_valid_reg;
    logic             s1_cmd_reg;
    logic [3:0]       s1_index_reg;
    logic [LANES-1:0] s1_raw_reg;
    logic [LANES-1:0] s1_mask_reg;
    logic             s1_row_valid_reg;
    logic             s1_fwd_reg;
    logic             s1_go;
    logic [AW-1:0]    s1_addr;

    logic [DEPTH-1:0]     row_valid_reg;
    logic [LANES-1:0]     fwd_stable_reg;
    logic [ROW_CNT_W-1:0] fwd_cnt_reg;

    logic [LANES-1:0]     rd_stable;
    logic [ROW_CNT_W-1:0] rd_cnt;
    logic [LANES-1:0]     cur_stable;
    logic [ROW_CNT_W-1:0] cur_cnt;
    logic [LANES-1:0]     new_stable;
    logic [ROW_CNT_W-1:0] new_cnt;
    logic [LANES-1:0]     ev_mask;
    logic [LANES-1:0]     wr_stable;
    logic [ROW_CNT_W-1:0] wr_cnt;

    bcd_load_t load;
    logic      emit_free;

    // configuration
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg    <= THRESHOLD_RESET;
            button_count_reg <= BUTTON_COUNT_RESET;
            active_low_reg   <= ACTIVE_LOW_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.payload.index)
                CFG_THRESHOLD:    threshold_reg    <= cfg.payload.data;
                CFG_BUTTON_COUNT: button_count_reg <= cfg.payload.data;
                CFG_ACTIVE_LOW:   active_low_reg   <= cfg.payload.data[0];
                default:          ;
            endcase
        end
    end

    // accept side: invert (when active low), mask and start the row read
    assign scan_xfer  = scan.valid && scan.ready;
    assign scan.ready = !s1_valid_reg || s1_go;
    assign beyond     = CW'({scan.payload.byte_index, 3'b000}) >= CW'(MAX_BUTTONS);
    assign inv_byte   = active_low_reg ? ~scan.payload.raw_byte : scan.payload.raw_byte;
    assign rd_addr    = scan.payload.byte_index[AW-1:0];
    assign rd_en      = scan_xfer && !beyond;

    always_comb
    begin
        for (int b = 0; b < LANES; b++)
        begin
            used[b] = (CW'({scan.payload.byte_index, 3'(b)}) < CW'(button_count_reg))
                   && (CW'({scan.payload.byte_index, 3'(b)}) < CW'(MAX_BUTTONS));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (scan_xfer)
        begin
            s1_valid_reg <= !beyond;
        end
        else if (s1_go)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            s1_cmd_reg       <= scan.payload.command;
            s1_index_reg     <= scan.payload.byte_index;
            s1_raw_reg       <= inv_byte & used;
            s1_mask_reg      <= used;
            s1_row_valid_reg <= row_valid_reg[rd_addr];
            // the row is written at the same edge as it is read
            s1_fwd_reg       <= s1_go && (s1_addr == rd_addr);
        end
        if (s1_go)
        begin
            fwd_stable_reg <= wr_stable;
            fwd_cnt_reg    <= wr_cnt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
        end
        else if (s1_go)
        begin
            row_valid_reg[s1_addr] <= 1'b1;
        end
    end

    bcd_ram #(
        .WIDTH (LANES),
        .DEPTH (DEPTH)
    ) u_stable_ram (
        .clk   (clk),
        .we    (s1_go),
        .waddr (s1_addr),
        .wdata (wr_stable),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_stable)
    );

    bcd_ram #(
        .WIDTH (ROW_CNT_W),
        .DEPTH (DEPTH)
    ) u_count_ram (
        .clk   (clk),
        .we    (s1_go),
        .waddr (s1_addr),
        .wdata (wr_cnt),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_cnt)
    );

    // ram stage: per-button debounce and write-back
    assign s1_addr = s1_index_reg[AW-1:0];
    assign s1_go   = s1_valid_reg && emit_free;

    assign cur_stable = s1_fwd_reg ? fwd_stable_reg
                                   : (s1_row_valid_reg ? rd_stable : '0);
    assign cur_cnt    = s1_fwd_reg ? fwd_cnt_reg
                                   : (s1_row_valid_reg ? rd_cnt : '0);

    always_comb
    begin
        logic [CNT_W-1:0] cnt_lane;
        logic [CNT_W-1:0] cnt_inc;
        new_stable = cur_stable;
        new_cnt    = cur_cnt;
        ev_mask    = '0;
        for (int b = 0; b < LANES; b++)
        begin
            cnt_lane = cur_cnt[b*CNT_W +: CNT_W];
            cnt_inc  = (cnt_lane < threshold_reg) ? cnt_lane + 1'b1 : cnt_lane;
            if (s1_mask_reg[b])
            begin
                if (s1_raw_reg[b] == cur_stable[b])
                begin
                    new_cnt[b*CNT_W +: CNT_W] = '0;
                end
                else if (cnt_inc >= threshold_reg)
                begin
                    new_stable[b]             = s1_raw_reg[b];
                    new_cnt[b*CNT_W +: CNT_W] = '0;
                    ev_mask[b]                = 1'b1;
                end
                else
                begin
                    new_cnt[b*CNT_W +: CNT_W] = cnt_inc;
                end
            end
        end
    end

    // priming takes the masked byte and leaves the counters as they are
    assign wr_stable = (s1_cmd_reg == CMD_PRIME) ? s1_raw_reg : new_stable;
    assign wr_cnt    = (s1_cmd_reg == CMD_PRIME) ? cur_cnt : new_cnt;

    assign load.valid      = s1_go;
    assign load.mask       = (s1_cmd_reg == CMD_PRIME) ? '0 : ev_mask;
    assign load.press      = s1_raw_reg;
    assign load.byte_index = s1_index_reg;

    bcd_emitter u_emitter (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (load),
        .free  (emit_free),
        .evt   (evt)
    );

    a_write_only_from_stage: assert property (@(posedge clk) disable iff (!rst_n)
        s1_go |-> s1_valid_reg)
        else $error("ram written with no byte in the ram stage");

    a_taken_enters_stage: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |=> s1_valid_reg)
        else $error("accepted byte did not reach the ram stage");

    a_stalled_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_go |=> s1_valid_reg && $stable(s1_index_reg)
                                   && $stable(s1_raw_reg))
        else $error("stalled ram stage lost its byte");

    a_prime_no_events: assert property (@(posedge clk) disable iff (!rst_n)
        s1_go && (s1_cmd_reg == CMD_PRIME) |=> !evt.valid)
        else $error("prime command produced an event");
endmodule

// File: hw/rtl/bcd_ram.sv
// generic single-port-write, single-port-read ram with registered read
module bcd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

// File: hw/rtl/bcd_emitter.sv
// serialises the press and release events of one byte, lowest button first
module bcd_emitter (
    input  logic               clk,
    input  logic               rst_n,
    input  bcd_pkg::bcd_load_t load,
    output logic               free,
    bcd_stream_if.source       evt
);
    import bcd_pkg::*;

    logic [LANES-1:0] mask_reg, mask_next;
    logic [LANES-1:0] press_reg;
    logic [3:0]       index_reg;
    logic [2:0]       low_bit;
    logic             last;
    logic             out_xfer;

    always_comb
    begin
        low_bit = 3'd0;
        for (int b = LANES - 1; b >= 0; b--)
        begin
            if (mask_reg[b])
            begin
                low_bit = 3'(b);
            end
        end
    end

    assign last     = (mask_reg & (mask_reg - 1'b1)) == '0;
    assign out_xfer = evt.valid && evt.ready;
    assign free     = (mask_reg == '0) || (last && evt.ready);

    assign evt.valid                 = mask_reg != '0;
    assign evt.payload.button_number = 8'({1'b0, index_reg, low_bit}) + 8'd1;
    assign evt.payload.pressed       = press_reg[low_bit];
    assign evt.payload.last_event    = last;

    always_comb
    begin
        mask_next = mask_reg;
        if (load.valid)
        begin
            mask_next = load.mask;
        end
        else if (out_xfer)
        begin
            mask_next = mask_reg & (mask_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= '0;
        end
        else
        begin
            mask_reg <= mask_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load.valid)
        begin
            press_reg <= load.press;
            index_reg <= load.byte_index;
        end
    end

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        load.valid |-> free)
        else $error("emitter loaded while events still pending");

    a_more_after_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_xfer && !last |=> evt.valid)
        else $error("events of a byte lost before its last event");

    a_pending_kept: assert property (@(posedge clk) disable iff (!rst_n)
        evt.valid && !evt.ready |=> evt.valid && $stable(evt.payload.button_number))
        else $error("pending event changed without a transfer");
endmodule
